// ===== design/sccr_pkg.sv =====
// Package for the sector cache controller: action codes, state types, request and result structs.
// No dependencies.
package sccr_pkg;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CLOCK,
        ST_FILL,
        ST_FLUSH,
        ST_OUT
    } t_state;

    localparam int IN_SECTOR_BITS = 32;
    localparam int OUT_ENTRY_BITS = 6;
    localparam int OUT_SECTOR_BITS = 32;

    typedef struct packed {
        t_action                   action;
        logic [IN_SECTOR_BITS-1:0] sector;
    } t_request;

    typedef struct packed {
        logic                       hit;
        logic [OUT_ENTRY_BITS-1:0]  entry;
        logic                       fill_needed;
        logic                       writeback_valid;
        logic [OUT_SECTOR_BITS-1:0] writeback_sector;
        logic                       last;
    } t_result;

endpackage

// ===== design/sccr_if.sv =====
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface sccr_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/sccr_cell.sv =====
// One cache entry: tag, flag bits and match compare.
// Depends on nothing.
module sccr_cell #(
    parameter int SECTOR_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [SECTOR_BITS-1:0] i_sector,
    input  logic                   i_fill,
    input  logic                   i_set_ref,
    input  logic                   i_clr_ref,
    input  logic                   i_set_dirty,
    input  logic                   i_flush_clr,
    output logic                   o_match,
    output logic                   o_used,
    output logic                   o_ref,
    output logic                   o_dirty,
    output logic [SECTOR_BITS-1:0] o_tag
);
    logic [SECTOR_BITS-1:0] r_tag;
    logic r_valid, r_used, r_ref, r_dirty;

    always_ff @(posedge i_clk) begin
        if (i_fill) r_tag <= i_sector;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_used  <= 1'b0;
            r_ref   <= 1'b0;
            r_dirty <= 1'b0;
        end else begin
            if (i_fill) begin
                r_valid <= 1'b1;
                r_used  <= 1'b1;
            end else if (i_flush_clr) begin
                r_used <= 1'b0;
            end
            // set wins over clear for both reference and dirty; fill clears dirty
            if (i_set_ref) r_ref <= 1'b1;
            else if (i_clr_ref || i_flush_clr) r_ref <= 1'b0;
            if (i_set_dirty) r_dirty <= 1'b1;
            else if (i_fill || i_flush_clr) r_dirty <= 1'b0;
        end
    end

    assign o_match = r_valid && (r_tag == i_sector);
    assign o_used  = r_used;
    assign o_ref   = r_ref;
    assign o_dirty = r_dirty;
    assign o_tag   = r_tag;
endmodule

// ===== design/sector_cache_clock_replacement.sv =====
// Top level: row of entry cells, lookup, clock hand and flush sequencer.
// Depends on sccr_pkg, sccr_if, sccr_cell.
//
//  channel | dir | payload
//  i_req   | in  | action, sector
//  o_rsp   | out | hit, entry, fill_needed, writeback_valid, writeback_sector, last
//
// Hit: accept, registered lookup, result. Miss with a free entry: accept, lookup,
// fill, result. Clock miss: accept, lookup, a clock step for each reference bit
// the hand clears and one for the victim, fill, result. Flush: a scan step for
// each entry scanned plus a result per dirty entry, held while the result waits.
// Reset restores empty cache, hand at the last entry; no clearing pass.
// Requests are refused until the current request and all its results are done.
module sector_cache_clock_replacement #(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    sccr_if.sink   i_req,
    sccr_if.source o_rsp
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = sccr_pkg::OUT_ENTRY_BITS;
    localparam int SW = sccr_pkg::OUT_SECTOR_BITS;

    sccr_pkg::t_state r_state, n_state;
    sccr_pkg::t_action r_act;
    logic [SECTOR_BITS-1:0] r_sector;
    logic [IW-1:0] r_hand, r_idx;
    logic r_hit, r_fill, r_wbv, r_last;
    logic [IW-1:0] r_entry;
    logic [SECTOR_BITS-1:0] r_wbs;

    logic [ENTRIES-1:0] w_match, w_used, w_ref, w_dirty;
    logic [ENTRIES-1:0] w_fill, w_setref, w_clrref, w_setdirty, w_flclr;
    logic [SECTOR_BITS-1:0] w_tag [ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        sccr_cell #(.SECTOR_BITS(SECTOR_BITS)) u_cell (
            .i_clk, .i_rst_n,
            .i_sector(r_sector), .i_fill(w_fill[g]), .i_set_ref(w_setref[g]),
            .i_clr_ref(w_clrref[g]), .i_set_dirty(w_setdirty[g]),
            .i_flush_clr(w_flclr[g]),
            .o_match(w_match[g]), .o_used(w_used[g]), .o_ref(w_ref[g]),
            .o_dirty(w_dirty[g]), .o_tag(w_tag[g])
        );
    end

    // lowest match and lowest unused
    logic [IW-1:0] w_mi, w_ui;
    logic w_mf, w_uf;
    always_comb begin
        w_mi = '0; w_mf = 1'b0; w_ui = '0; w_uf = 1'b0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (w_match[k]) begin w_mi = IW'(k); w_mf = 1'b1; end
            if (!w_used[k]) begin w_ui = IW'(k); w_uf = 1'b1; end
        end
    end

    logic [IW-1:0] w_hand_nx;
    assign w_hand_nx = (r_hand == IW'(ENTRIES - 1)) ? '0 : r_hand + 1'b1;
    logic [IW-1:0] w_idx_nx;
    assign w_idx_nx = (r_idx == IW'(ENTRIES - 1)) ? '0 : r_idx + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sccr_pkg::ST_IDLE:
                if (i_req.valid) begin
                    if (i_req.data.action == sccr_pkg::ACT_FLUSH) n_state = sccr_pkg::ST_FLUSH;
                    else if (i_req.data.action != sccr_pkg::ACT_NONE) n_state = sccr_pkg::ST_LOOKUP;
                end
            sccr_pkg::ST_LOOKUP:
                if (w_mf) n_state = sccr_pkg::ST_OUT;
                else if (w_uf) n_state = sccr_pkg::ST_FILL;
                else n_state = sccr_pkg::ST_CLOCK;
            sccr_pkg::ST_CLOCK:
                if (!w_ref[w_hand_nx]) n_state = sccr_pkg::ST_FILL;
            sccr_pkg::ST_FILL:  n_state = sccr_pkg::ST_OUT;
            sccr_pkg::ST_FLUSH:
                if (w_dirty[r_idx]) n_state = sccr_pkg::ST_OUT;
                else if (r_idx == IW'(ENTRIES - 1)) n_state = sccr_pkg::ST_IDLE;
            sccr_pkg::ST_OUT:
                if (o_rsp.ready) begin
                    if (r_act == sccr_pkg::ACT_FLUSH && !r_last) n_state = sccr_pkg::ST_FLUSH;
                    else n_state = sccr_pkg::ST_IDLE;
                end
            default: n_state = sccr_pkg::ST_IDLE;
        endcase
    end

    // does any dirty entry lie above the current flush index
    logic w_more;
    always_comb begin
        w_more = 1'b0;
        for (int k = 0; k < ENTRIES; k++)
            if (IW'(k) > r_idx && w_dirty[k]) w_more = 1'b1;
    end

    always_comb begin
        w_fill = '0; w_setref = '0; w_clrref = '0; w_setdirty = '0; w_flclr = '0;
        unique case (r_state)
            sccr_pkg::ST_CLOCK:
                if (w_ref[w_hand_nx]) w_clrref[w_hand_nx] = 1'b1;
            sccr_pkg::ST_LOOKUP:
                if (w_mf) begin
                    w_setref[w_mi] = 1'b1;
                    w_setdirty[w_mi] = (r_act == sccr_pkg::ACT_WRITE);
                end
            sccr_pkg::ST_FILL: begin
                w_fill[r_entry] = 1'b1;
                w_setref[r_entry] = 1'b1;
                w_setdirty[r_entry] = (r_act == sccr_pkg::ACT_WRITE);
            end
            sccr_pkg::ST_FLUSH:
                if (w_dirty[r_idx]) w_flclr[r_idx] = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sccr_pkg::ST_IDLE;
            r_hand  <= IW'(ENTRIES - 1);
        end else begin
            r_state <= n_state;
            if (r_state == sccr_pkg::ST_CLOCK) r_hand <= w_hand_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sccr_pkg::ST_IDLE: begin
                r_act    <= sccr_pkg::t_action'(i_req.data.action);
                r_sector <= SECTOR_BITS'(i_req.data.sector);
                r_idx    <= '0;
            end
            sccr_pkg::ST_LOOKUP: begin
                r_hit <= w_mf; r_fill <= !w_mf; r_last <= 1'b1; r_wbv <= 1'b0;
                r_wbs <= '0;
                r_entry <= w_mf ? w_mi : w_ui;
                if (!w_mf && w_uf) begin
                    r_wbv <= w_dirty[w_ui]; r_wbs <= w_tag[w_ui];
                end
            end
            sccr_pkg::ST_CLOCK:
                if (!w_ref[w_hand_nx]) begin
                    r_entry <= w_hand_nx;
                    r_wbv <= w_dirty[w_hand_nx]; r_wbs <= w_tag[w_hand_nx];
                end
            sccr_pkg::ST_FLUSH: begin
                r_hit <= 1'b0; r_fill <= 1'b0; r_wbv <= 1'b1;
                r_entry <= r_idx; r_wbs <= w_tag[r_idx];
                r_last <= !w_more;
                r_idx <= w_idx_nx;
            end
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == sccr_pkg::ST_IDLE);
    assign o_rsp.valid = (r_state == sccr_pkg::ST_OUT);
    always_comb begin
        o_rsp.data.hit              = r_hit;
        o_rsp.data.entry            = OW'(r_entry);
        o_rsp.data.fill_needed      = r_fill;
        o_rsp.data.writeback_valid  = r_wbv;
        o_rsp.data.writeback_sector = r_wbv ? SW'(r_wbs) : '0;
        o_rsp.data.last             = r_last;
    end
endmodule

// ===== design/sccr_checker.sv =====
// Port-level checker for the sector cache controller, bound to the top level.
// Depends on sccr_pkg and, for the bind, the top level.
module sccr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic o_rsp_valid,
    input logic o_rsp_ready,
    input sccr_pkg::t_result o_rsp_data
);
    // no request taken while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req_ready && o_rsp_valid)) else $error("request taken with result pending");
    // a result never directly follows a taken request; a lookup or flush step lies between
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !o_rsp_valid)
        else $error("result right after request");
    a_hitfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp_data.hit && o_rsp_data.fill_needed))
        else $error("hit with fill");
    a_hitwb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_data.hit |-> !o_rsp_data.writeback_valid && o_rsp_data.last)
        else $error("hit with writeback");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_data))
        else $error("result dropped");
endmodule

bind sector_cache_clock_replacement sccr_checker u_sccr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid), .i_req_ready(i_req.ready),
    .o_rsp_valid(o_rsp.valid), .o_rsp_ready(o_rsp.ready),
    .o_rsp_data(o_rsp.data)
);
